// ----- hdl/grc_pkg.sv -----
// Shared constants, types and codes for the grid ray caster.
// No dependencies.
package grc_pkg;

  localparam int GRID_SIDE  = 256;
  localparam int COORD_BITS = 12;
  localparam int GRID_AW    = $clog2(GRID_SIDE);
  localparam int CELL_W     = 8;
  localparam int MAP_W      = 9;
  localparam int OUT_W      = 13;
  localparam int DW         = COORD_BITS + 1;
  localparam int PW         = COORD_BITS + 2;
  localparam int DSW        = COORD_BITS + 4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic CFG_MAP_WIDTH  = 1'b0;
  localparam logic CFG_MAP_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    HIT_WALL   = 2'd0,
    HIT_LEFT   = 2'd1,
    HIT_PASSED = 2'd2
  } hit_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SETUP,
    ST_WALK
  } grc_state_t;

  typedef struct packed {
    logic               rd;
    logic               wr;
    logic [GRID_AW-1:0] row;
    logic [GRID_AW-1:0] col;
    logic               wall;
  } grc_grid_req_t;

endpackage

// ----- hdl/grc_grid.sv -----
// Occupancy grid: one row of cells per memory word, row valid bits for reset.
// Depends on grc_pkg.
module grc_grid import grc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  grc_grid_req_t req,
  output logic          rd_bit
);

  logic [GRID_SIDE-1:0] grid_mem_r [GRID_SIDE];
  logic [GRID_SIDE-1:0] row_q_r;
  logic [GRID_SIDE-1:0] row_merge;
  logic [GRID_SIDE-1:0] row_valid_r;
  logic                 row_vld_q_r;
  logic [GRID_AW-1:0]   col_q_r;

  // write-back merges into the row read in the previous cycle
  always_comb begin
    row_merge          = row_vld_q_r ? row_q_r : '0;
    row_merge[req.col] = req.wall;
  end

  always_ff @(posedge clk) begin
    if (req.wr) begin
      grid_mem_r[req.row] <= row_merge;
    end
    if (req.rd) begin
      row_q_r <= grid_mem_r[req.row];
      col_q_r <= req.col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      row_vld_q_r <= 1'b0;
    end else begin
      if (req.wr) begin
        row_valid_r[req.row] <= 1'b1;
      end
      if (req.rd) begin
        row_vld_q_r <= row_valid_r[req.row];
      end
    end
  end

  assign rd_bit = row_vld_q_r & row_q_r[col_q_r];

endmodule

// ----- hdl/grid_ray_cast_bresenham.sv -----
// Top level: request handshakes, map registers and the Bresenham walk sequencer.
// Depends on grc_pkg and grc_grid.
//
//   channel | direction | payload
//   in_     | in        | op, cell_col, cell_row, cell_is_wall, ray start/end x,y
//   out_    | out       | hit_dx, hit_dy, hit_status (one per cast request)
//   cfg_    | in        | cfg_index, cfg_data (map width, map height)
//
// Grid write: row read, then row write-back.
// Cast: setup reads the start cell, then the walk does one grid memory read per cell
// checked (at most max(|dx|,|dy|) + 2 cells); that one read per cell sets the pace.
// One request at a time; the next is taken while a result waits on out_.
// A finished cast holds in the walk until the output register is free.
// Reset clears only the grid's row valid bits, not its memory; no clearing pass is needed.
module grid_ray_cast_bresenham import grc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic [CELL_W-1:0]            in_cell_col,
  input  logic [CELL_W-1:0]            in_cell_row,
  input  logic                         in_cell_is_wall,
  input  logic signed [COORD_BITS-1:0] in_ray_start_x,
  input  logic signed [COORD_BITS-1:0] in_ray_start_y,
  input  logic signed [COORD_BITS-1:0] in_ray_end_x,
  input  logic signed [COORD_BITS-1:0] in_ray_end_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OUT_W-1:0]      out_hit_dx,
  output logic signed [OUT_W-1:0]      out_hit_dy,
  output logic [1:0]                   out_hit_status,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [MAP_W-1:0]             cfg_data
);

  grc_state_t state_r, state_nxt;
  grc_grid_req_t grid_req;
  logic grid_bit;

  logic [MAP_W-1:0] map_width_r, map_height_r;
  logic [MAP_W-1:0] w_eff, h_eff;

  logic [GRID_AW-1:0] wr_row_r, wr_col_r;
  logic               wr_wall_r;

  logic signed [COORD_BITS-1:0] sx_r, sy_r, ex_r, ey_r;
  logic signed [DW-1:0]         dx_r, dy_r;
  logic signed [PW-1:0]         px_r, py_r, px_nxt, py_nxt;
  logic signed [DSW-1:0]        disc_r, inc_diag_r, inc_str_r, disc_nxt;
  logic                         maj_y_r, neg_x_r, neg_y_r;

  logic [DW-1:0]         adx, ady, dmaj, dmin;
  logic                  maj_y;
  logic signed [DSW-1:0] dmaj_s, dmin_s;

  logic signed [PW-1:0] pmaj, emaj, w_ext, h_ext;
  logic                 neg_maj, passed, outside, walk_done, step_diag;
  logic                 slot_free, in_acc, step_go, out_load;

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_dx_r, out_dy_r, res_dx, res_dy;
  hit_status_t             out_status_r, res_status;

  grc_grid u_grid (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (grid_req),
    .rd_bit (grid_bit)
  );

  // effective map size
  assign w_eff = (int'(map_width_r) > GRID_SIDE) ? MAP_W'(GRID_SIDE) : map_width_r;
  assign h_eff = (int'(map_height_r) > GRID_SIDE) ? MAP_W'(GRID_SIDE) : map_height_r;
  assign w_ext = $signed(PW'(w_eff));
  assign h_ext = $signed(PW'(h_eff));

  // setup arithmetic
  always_comb begin
    adx    = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
    ady    = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);
    maj_y  = ady > adx;
    dmaj   = maj_y ? ady : adx;
    dmin   = maj_y ? adx : ady;
    dmaj_s = $signed(DSW'(dmaj));
    dmin_s = $signed(DSW'(dmin));
  end

  // walk checks and next point
  always_comb begin
    pmaj      = maj_y_r ? py_r : px_r;
    emaj      = maj_y_r ? PW'(ey_r) : PW'(ex_r);
    neg_maj   = maj_y_r ? neg_y_r : neg_x_r;
    passed    = neg_maj ? (pmaj < emaj) : (pmaj > emaj);
    outside   = px_r[PW-1] || (px_r == '0) || (px_r >= w_ext) ||
                py_r[PW-1] || (py_r == '0) || (py_r >= h_ext);
    walk_done = passed || outside || grid_bit;
    step_diag = disc_r > DSW'(0);
    px_nxt    = px_r;
    py_nxt    = py_r;
    if (!maj_y_r || step_diag) begin
      px_nxt = neg_x_r ? px_r - PW'(1) : px_r + PW'(1);
    end
    if (maj_y_r || step_diag) begin
      py_nxt = neg_y_r ? py_r - PW'(1) : py_r + PW'(1);
    end
    disc_nxt = step_diag ? disc_r + inc_diag_r : disc_r + inc_str_r;
  end

  // result selection, order decides
  always_comb begin
    priority if (passed) begin
      res_status = HIT_PASSED;
      res_dx     = OUT_W'(px_r - PW'(sx_r));
      res_dy     = OUT_W'(py_r - PW'(sy_r));
    end else if (outside) begin
      res_status = HIT_LEFT;
      res_dx     = OUT_W'(dx_r);
      res_dy     = OUT_W'(dy_r);
    end else begin
      res_status = HIT_WALL;
      res_dx     = OUT_W'(px_r - PW'(sx_r));
      res_dy     = OUT_W'(py_r - PW'(sy_r));
    end
  end

  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_CAST) begin
            state_nxt = ST_SETUP;
          end else if (int'(in_cell_col) < GRID_SIDE && int'(in_cell_row) < GRID_SIDE) begin
            state_nxt = ST_WRITE;
          end
        end
      end
      ST_WRITE: state_nxt = ST_IDLE;
      ST_SETUP: state_nxt = ST_WALK;
      ST_WALK: begin
        if (walk_done && slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    step_go  = 1'b0;
    out_load = 1'b0;
    grid_req = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        grid_req.rd   = in_valid && (in_op == OP_WRITE);
        grid_req.row  = GRID_AW'(in_cell_row);
        grid_req.col  = GRID_AW'(in_cell_col);
      end
      ST_WRITE: begin
        grid_req.wr   = 1'b1;
        grid_req.row  = wr_row_r;
        grid_req.col  = wr_col_r;
        grid_req.wall = wr_wall_r;
      end
      ST_SETUP: begin
        grid_req.rd   = 1'b1;
        grid_req.row  = GRID_AW'(py_r);
        grid_req.col  = GRID_AW'(px_r);
      end
      ST_WALK: begin
        out_load      = walk_done && slot_free;
        step_go       = !walk_done;
        grid_req.rd   = !walk_done;
        grid_req.row  = GRID_AW'(py_nxt);
        grid_req.col  = GRID_AW'(px_nxt);
      end
      default: ;
    endcase
  end

  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      wr_row_r  <= GRID_AW'(in_cell_row);
      wr_col_r  <= GRID_AW'(in_cell_col);
      wr_wall_r <= in_cell_is_wall;
      sx_r      <= in_ray_start_x;
      sy_r      <= in_ray_start_y;
      ex_r      <= in_ray_end_x;
      ey_r      <= in_ray_end_y;
      dx_r      <= DW'(in_ray_end_x) - DW'(in_ray_start_x);
      dy_r      <= DW'(in_ray_end_y) - DW'(in_ray_start_y);
      px_r      <= PW'(in_ray_start_x);
      py_r      <= PW'(in_ray_start_y);
    end
    if (state_r == ST_SETUP) begin
      maj_y_r    <= maj_y;
      neg_x_r    <= dx_r[DW-1];
      neg_y_r    <= dy_r[DW-1];
      disc_r     <= (dmin_s <<< 1) - dmaj_s;
      inc_diag_r <= (dmin_s - dmaj_s) <<< 1;
      inc_str_r  <= dmin_s <<< 1;
    end
    if (step_go) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      disc_r <= disc_nxt;
    end
    if (out_load) begin
      out_dx_r     <= res_dx;
      out_dy_r     <= res_dy;
      out_status_r <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      map_width_r  <= MAP_W'(256);
      map_height_r <= MAP_W'(256);
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MAP_WIDTH:  map_width_r  <= cfg_data;
          CFG_MAP_HEIGHT: map_height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_hit_dx     = out_dx_r;
  assign out_hit_dy     = out_dy_r;
  assign out_hit_status = out_status_r;

  a_wb_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    grid_req.wr |-> $past(grid_req.rd) && ($past(grid_req.row) == grid_req.row))
    else $error("grid write-back without read of the same row");

  a_first_read_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SETUP |=> state_r == ST_WALK && $past(grid_req.rd) &&
                            ($past(grid_req.row) == GRID_AW'(py_r)))
    else $error("walk did not start from the start cell read");

  a_major_advance: assert property (@(posedge clk) disable iff (!rst_n)
    step_go |=> (maj_y_r ? (py_r != $past(py_r)) : (px_r != $past(px_r))))
    else $error("walk step did not move along the major axis");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for grid_ray_cast_bresenham: grid writes and ray casts checked against
// fixed expected results and an in-bench Bresenham walk over a copy of the occupancy grid.
// Depends on grc_pkg and the grid_ray_cast_bresenham RTL.
module testbench;
  import grc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 160;
  localparam int SETTLE       = 20;

  typedef struct {
    logic signed [OUT_W-1:0] dx;
    logic signed [OUT_W-1:0] dy;
    hit_status_t             st;
  } hit_t;

  typedef struct {
    logic                         op;
    logic [CELL_W-1:0]            col;
    logic [CELL_W-1:0]            row;
    logic                         wall;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
    bit                           fixed;
    hit_t                         want;
  } grid_req_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_op;
  logic [CELL_W-1:0]            in_cell_col;
  logic [CELL_W-1:0]            in_cell_row;
  logic                         in_cell_is_wall;
  logic signed [COORD_BITS-1:0] in_ray_start_x;
  logic signed [COORD_BITS-1:0] in_ray_start_y;
  logic signed [COORD_BITS-1:0] in_ray_end_x;
  logic signed [COORD_BITS-1:0] in_ray_end_y;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [OUT_W-1:0]      out_hit_dx;
  logic signed [OUT_W-1:0]      out_hit_dy;
  logic [1:0]                   out_hit_status;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic                         cfg_index;
  logic [MAP_W-1:0]             cfg_data;

  bit        occ_model [GRID_SIDE*GRID_SIDE];
  int        map_w = 256;
  int        map_h = 256;
  hit_t      pending_hits [$];
  hit_t      head_hit;
  grid_req_t directed [$];
  int        err_count   = 0;
  int        cycle_count = 0;
  bit        steady      = 1'b0;

  grid_ray_cast_bresenham dut (.*);

  always begin
    clk = 1'b0;
    #1ns;
    clk = 1'b1;
    #1ns;
  end

  task automatic flag_error(string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  task automatic add_row(grid_req_t r);
    directed = {directed, r};
  endtask

  // Bresenham walk; past-end test, outside test and wall test before each step
  function automatic hit_t trace_ray(int sx, int sy, int ex, int ey);
    int   w, h, mj, mn, err;
    int   dlt [2];
    int   dir [2];
    int   pos [2];
    int   fin [2];
    hit_t res;
    w = (map_w > GRID_SIDE) ? GRID_SIDE : map_w;
    h = (map_h > GRID_SIDE) ? GRID_SIDE : map_h;
    dlt[0] = ex - sx;
    dlt[1] = ey - sy;
    dir[0] = (dlt[0] < 0) ? -1 : 1;
    dir[1] = (dlt[1] < 0) ? -1 : 1;
    dlt[0] = (dlt[0] < 0) ? -dlt[0] : dlt[0];
    dlt[1] = (dlt[1] < 0) ? -dlt[1] : dlt[1];
    mj = (dlt[1] > dlt[0]) ? 1 : 0;
    mn = 1 - mj;
    pos[0] = sx;
    pos[1] = sy;
    fin[0] = ex;
    fin[1] = ey;
    err = 2 * dlt[mn] - dlt[mj];
    forever begin
      if ((pos[mj] - fin[mj]) * dir[mj] > 0) begin
        res.dx = OUT_W'(pos[0] - sx);
        res.dy = OUT_W'(pos[1] - sy);
        res.st = HIT_PASSED;
        return res;
      end
      if (pos[0] <= 0 || pos[0] >= w || pos[1] <= 0 || pos[1] >= h) begin
        res.dx = OUT_W'(ex - sx);
        res.dy = OUT_W'(ey - sy);
        res.st = HIT_LEFT;
        return res;
      end
      if (occ_model[pos[1] * GRID_SIDE + pos[0]]) begin
        res.dx = OUT_W'(pos[0] - sx);
        res.dy = OUT_W'(pos[1] - sy);
        res.st = HIT_WALL;
        return res;
      end
      if (err > 0) begin
        pos[mn] += dir[mn];
        err += 2 * (dlt[mn] - dlt[mj]);
      end else begin
        err += 2 * dlt[mn];
      end
      pos[mj] += dir[mj];
    end
  endfunction

  function automatic grid_req_t mk_req(logic op, int col, int row, logic wall,
                                       int sx, int sy, int ex, int ey);
    grid_req_t r;
    r.op      = op;
    r.col     = CELL_W'(col);
    r.row     = CELL_W'(row);
    r.wall    = wall;
    r.sx      = COORD_BITS'(sx);
    r.sy      = COORD_BITS'(sy);
    r.ex      = COORD_BITS'(ex);
    r.ey      = COORD_BITS'(ey);
    r.fixed   = 1'b0;
    r.want.dx = '0;
    r.want.dy = '0;
    r.want.st = HIT_WALL;
    return r;
  endfunction

  function automatic grid_req_t mk_chk(int sx, int sy, int ex, int ey,
                                       int dx, int dy, hit_status_t st);
    grid_req_t r;
    r         = mk_req(OP_CAST, 0, 0, 1'b0, sx, sy, ex, ey);
    r.fixed   = 1'b1;
    r.want.dx = OUT_W'(dx);
    r.want.dy = OUT_W'(dy);
    r.want.st = st;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_req(grid_req_t r);
    int gap;
    in_valid        <= 1'b1;
    in_op           <= r.op;
    in_cell_col     <= r.col;
    in_cell_row     <= r.row;
    in_cell_is_wall <= r.wall;
    in_ray_start_x  <= r.sx;
    in_ray_start_y  <= r.sy;
    in_ray_end_x    <= r.ex;
    in_ray_end_y    <= r.ey;
    do @(posedge clk); while (!in_ready);
    if (r.op == OP_WRITE)
      occ_model[int'(r.row) * GRID_SIDE + int'(r.col)] = r.wall;
    else if (r.fixed)
      pending_hits = {pending_hits, r.want};
    else
      pending_hits = {pending_hits, trace_ray(r.sx, r.sy, r.ex, r.ey)};
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_hits();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_map_reg(logic idx, logic [MAP_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MAP_WIDTH) map_w = val;
    else map_h = val;
  endtask

  // random request: mostly wall writes and short casts around a window
  function automatic grid_req_t rand_req(int wx, int wy);
    int pick, sx, sy, len, w;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      if ($urandom_range(0, 4) != 0)
        return mk_req(OP_WRITE, wx + $urandom_range(0, 31), wy + $urandom_range(0, 31),
                      $urandom_range(0, 9) < 6, 0, 0, 0, 0);
      return mk_req(OP_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                    1'($urandom_range(0, 1)), 0, 0, 0, 0);
    end
    if (pick < 85) begin
      w = (map_w > GRID_SIDE) ? GRID_SIDE : map_w;
      if ($urandom_range(0, 9) < 7 || w < 2) begin
        sx = wx + $urandom_range(0, 31);
        sy = wy + $urandom_range(0, 31);
      end else begin
        sx = $urandom_range(1, w - 1);
        sy = $urandom_range(1, 255);
      end
      len = ($urandom_range(0, 99) < 85) ? 24 : 300;
      return mk_req(OP_CAST, 0, 0, 1'b0, sx, sy,
                    sx + $urandom_range(0, 2 * len) - len,
                    sy + $urandom_range(0, 2 * len) - len);
    end
    return mk_req(OP_CAST, $urandom_range(0, 255), $urandom_range(0, 255),
                  1'($urandom_range(0, 1)), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 4095));
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_hits.size() == 0) begin
        flag_error($sformatf("unexpected result dx=%0d dy=%0d status=%0d",
                             out_hit_dx, out_hit_dy, out_hit_status));
      end else begin
        head_hit = pending_hits.pop_front();
        if (out_hit_dx !== head_hit.dx)
          flag_error($sformatf("hit_dx got %0d want %0d", out_hit_dx, head_hit.dx));
        if (out_hit_dy !== head_hit.dy)
          flag_error($sformatf("hit_dy got %0d want %0d", out_hit_dy, head_hit.dy));
        if (out_hit_status !== head_hit.st)
          flag_error($sformatf("hit_status got %0d want %0d", out_hit_status,
                               head_hit.st));
      end
    end
  end

  initial begin
    int stall;
    out_ready <= 1'b0;
    wait (rst_n);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    int        phase_w [PHASES] = '{256, 0, 256, 511, 1, 2, 255, 257, 100, 0};
    int        phase_h [PHASES] = '{256, 256, 0, 511, 1, 2, 256, 64, 200, 0};
    int        wx, wy;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_op           <= OP_WRITE;
    in_cell_col     <= '0;
    in_cell_row     <= '0;
    in_cell_is_wall <= 1'b0;
    in_ray_start_x  <= '0;
    in_ray_start_y  <= '0;
    in_ray_end_x    <= '0;
    in_ray_end_y    <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_MAP_WIDTH;
    cfg_data        <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset map is 256 x 256 and all free
    add_row(mk_chk(0, 0, 10, 10, 10, 10, HIT_LEFT));
    add_row(mk_chk(5, 5, 5, 5, 1, 0, HIT_PASSED));
    add_row(mk_chk(2047, 2047, -2048, -2048, -4095, -4095, HIT_LEFT));
    add_row(mk_chk(-2048, -2048, 2047, 2047, 4095, 4095, HIT_LEFT));
    add_row(mk_req(OP_WRITE, 0, 0, 1'b1, 0, 0, 0, 0));
    add_row(mk_req(OP_WRITE, 255, 255, 1'b1, 0, 0, 0, 0));
    add_row(mk_req(OP_WRITE, 20, 10, 1'b1, 0, 0, 0, 0));
    add_row(mk_chk(10, 10, 30, 10, 10, 0, HIT_WALL));
    add_row(mk_chk(10, 10, 15, 10, 6, 0, HIT_PASSED));
    add_row(mk_chk(10, 12, 260, 12, 250, 0, HIT_LEFT));
    add_row(mk_chk(250, 250, 255, 255, 5, 5, HIT_WALL));
    add_row(mk_chk(255, 255, 255, 255, 0, 0, HIT_WALL));
    add_row(mk_req(OP_CAST, 0, 0, 1'b0, 40, 40, 45, 60));
    add_row(mk_req(OP_CAST, 0, 0, 1'b0, 60, 60, 30, 50));
    add_row(mk_req(OP_CAST, 0, 0, 1'b0, 100, 100, 100, 40));
    add_row(mk_req(OP_CAST, 0, 0, 1'b0, 100, 100, -5, 100));
    add_row(mk_req(OP_WRITE, 20, 10, 1'b0, 0, 0, 0, 0));
    add_row(mk_chk(10, 10, 30, 10, 21, 0, HIT_PASSED));
    add_row(mk_chk(1, 1, 1, 1, 1, 0, HIT_PASSED));
    add_row(mk_req(OP_WRITE, 255, 0, 1'b1, 0, 0, 0, 0));
    add_row(mk_req(OP_WRITE, 0, 255, 1'b1, 0, 0, 0, 0));
    add_row(mk_req(OP_CAST, 0, 0, 1'b0, 200, 3, 3, 250));
    foreach (directed[i]) send_req(directed[i]);

    for (int p = 0; p < PHASES; p++) begin
      drain_hits();
      if (p == PHASES - 1) begin
        phase_w[p] = $urandom_range(0, 511);
        phase_h[p] = $urandom_range(0, 511);
      end
      set_map_reg(CFG_MAP_WIDTH, MAP_W'(phase_w[p]));
      set_map_reg(CFG_MAP_HEIGHT, MAP_W'(phase_h[p]));
      cfg_valid <= 1'b0;
      steady = (p == 0) || ($urandom_range(0, 3) == 0);
      wx = $urandom_range(1, 223);
      wy = $urandom_range(1, 223);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_req(rand_req(wx, wy));
        if ($urandom_range(0, 79) == 0) drain_hits();
      end
    end

    drain_hits();
    repeat (50) @(posedge clk);
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/grc_pkg.sv
hdl/grc_grid.sv
hdl/grid_ray_cast_bresenham.sv
bench/testbench.sv
